### src/ncbf_pkg.sv
// ----------------------------------------------------------------------------
// ncbf_pkg
// Shared widths, constants, register indexes and the sequencer microcode
// for the n-gram counting Bloom filter.
// ----------------------------------------------------------------------------
package ncbf_pkg;

  // Field and register widths fixed by the interface.
  localparam int TOKEN_W       = 32;
  localparam int NGRAM_LEN_W   = 4;
  localparam int MIN_COUNT_W   = 8;
  localparam int NUM_BUCKETS_W = 17;
  localparam int BUCKET_W      = 16;
  localparam int COUNT_W       = 8;
  localparam int HASH_W        = 64;
  localparam int IN_DATA_W     = 32;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 17;

  // Defaults for the top level parameters.
  localparam int DEF_FILTER_ENTRIES = 65536;
  localparam int DEF_MAX_NGRAM      = 10;

  // FNV-1a 64. The prime is 2^40 + 2^8 + 0xB3, so a multiply by it is a
  // byte multiply plus two shifted adds.
  localparam logic [HASH_W-1:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
  localparam logic [7:0]        FNV_PRIME_LO = 8'hB3;
  localparam int                FNV_SHIFT_A = 8;
  localparam int                FNV_SHIFT_B = 40;

  localparam logic [COUNT_W-1:0] CNT_MAX = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [NGRAM_LEN_W-1:0]   RST_NGRAM_LEN   = 4'd2;
  localparam logic [MIN_COUNT_W-1:0]   RST_MIN_COUNT   = 8'd2;
  localparam logic [NUM_BUCKETS_W-1:0] RST_NUM_BUCKETS = 17'h1_0000;

  // Request kinds.
  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_NGRAM_LEN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_COUNT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_BUCKETS = 2'd2;

  // Datapath operations.
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_ACCEPT = 4'd2;
  localparam logic [3:0] OP_HINIT  = 4'd3;
  localparam logic [3:0] OP_MULA   = 4'd4;
  localparam logic [3:0] OP_MULB   = 4'd5;
  localparam logic [3:0] OP_DIVI   = 4'd6;
  localparam logic [3:0] OP_DIVS   = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;
  localparam logic [3:0] OP_UPDATE = 4'd9;
  localparam logic [3:0] OP_EMIT   = 4'd10;

  // Hold conditions: while true the step counter stays put.
  localparam logic [2:0] H_NONE     = 3'd0;
  localparam logic [2:0] H_CLEAR    = 3'd1;
  localparam logic [2:0] H_NO_INPUT = 3'd2;
  localparam logic [2:0] H_DIV      = 3'd3;
  localparam logic [2:0] H_OUT_BUSY = 3'd4;

  // Jump conditions: when true (and not holding) go to the target step.
  localparam logic [1:0] J_NONE     = 2'd0;
  localparam logic [1:0] J_ALWAYS   = 2'd1;
  localparam logic [1:0] J_NOT_FULL = 2'd2;
  localparam logic [1:0] J_MORE_TOK = 2'd3;

  // Program steps.
  localparam int         STEP_W   = 4;
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_MULA   = 4'd3;
  localparam logic [3:0] S_MULB   = 4'd4;
  localparam logic [3:0] S_DIVI   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_UPDATE = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  typedef struct packed {
    logic [3:0]        op;
    logic [2:0]        hold;
    logic [1:0]        jump;
    logic [STEP_W-1:0] tgt;
  } uword_t;

  // The control store.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_CLEAR:  w = '{OP_CLEAR,  H_CLEAR,    J_NONE,     S_IDLE};
      S_IDLE:   w = '{OP_ACCEPT, H_NO_INPUT, J_NONE,     S_IDLE};
      S_CHECK:  w = '{OP_HINIT,  H_NONE,     J_NOT_FULL, S_EMIT};
      S_MULA:   w = '{OP_MULA,   H_NONE,     J_NONE,     S_IDLE};
      S_MULB:   w = '{OP_MULB,   H_NONE,     J_MORE_TOK, S_MULA};
      S_DIVI:   w = '{OP_DIVI,   H_NONE,     J_NONE,     S_IDLE};
      S_DIV:    w = '{OP_DIVS,   H_DIV,      J_NONE,     S_IDLE};
      S_READ:   w = '{OP_READ,   H_NONE,     J_NONE,     S_IDLE};
      S_UPDATE: w = '{OP_UPDATE, H_NONE,     J_NONE,     S_IDLE};
      S_EMIT:   w = '{OP_EMIT,   H_OUT_BUSY, J_ALWAYS,   S_IDLE};
      default:  w = '{OP_NOP,    H_NONE,     J_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/ncbf_ram.sv
// ----------------------------------------------------------------------------
// ncbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ncbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/ngram_counting_bloom_filter.sv
// ----------------------------------------------------------------------------
// ngram_counting_bloom_filter
// Counting Bloom filter over token n-grams, one FNV-1a 64-bit hash.
//
// Each input transfer carries one 32-bit token id, a count/query kind and a
// document-start flag; each one gives exactly one output transfer. The block
// keeps the newest tokens of the current document; once the window holds
// ngram_len tokens it hashes them oldest first, reduces the hash modulo the
// configured number of buckets and either increments that 8-bit counter
// (saturating at 255) or reports whether it has reached min_count. Items are
// handled one at a time by a microcoded sequencer: a full window is hashed
// token by token and reduced by the 64-step bit-serial remainder unit;
// the bucket is then read, updated on a count, and the result emitted. An
// item whose window is not yet full goes from the window check straight
// to the emit step. The next item is taken while a result still waits in
// the output register. After reset the counter RAM is swept to zero, one
// entry per cycle, all FILTER_ENTRIES (65536 by default) of them, before
// the first input is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ngram_counting_bloom_filter
  import ncbf_pkg::*;
#(
  parameter int FILTER_ENTRIES = DEF_FILTER_ENTRIES,
  parameter int MAX_NGRAM      = DEF_MAX_NGRAM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] token_id
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] req_type, [1] doc_start
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] bucket, [23:16] count_value,
                                            // [24] passed, [31:25] zero
  output logic                  out_tuser   // [0] ngram_valid
);

  // Derived widths.
  localparam int ADDR_W    = $clog2(FILTER_ENTRIES);
  localparam int SIZE_W    = $clog2(FILTER_ENTRIES + 1);
  localparam int CMP_W     = (SIZE_W > NUM_BUCKETS_W) ? SIZE_W : NUM_BUCKETS_W;
  localparam int LEN_W     = $clog2(MAX_NGRAM + 1);
  localparam int IDX_W     = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
  localparam int DIV_STEPS = HASH_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int PAD_W     = OUT_DATA_W - BUCKET_W - COUNT_W - 1;

  // Configuration registers.
  logic [NGRAM_LEN_W-1:0]   ngram_len_r;
  logic [MIN_COUNT_W-1:0]   min_count_r;
  logic [NUM_BUCKETS_W-1:0] num_buckets_r;

  // Sequencer.
  logic [STEP_W-1:0] pc_r, pc_nxt;
  uword_t            uw;
  logic              hold;
  logic              jump;

  // Window and datapath.
  logic [TOKEN_W-1:0] win_r   [MAX_NGRAM];
  logic [TOKEN_W-1:0] win_nxt [MAX_NGRAM];
  logic [LEN_W-1:0]   fill_r, fill_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [LEN_W-1:0]   k_m1;
  logic               req_r, req_nxt;
  logic               full_r, full_nxt;
  logic [HASH_W-1:0]  h_r, h_nxt;
  logic [HASH_W-1:0]  x_r, x_nxt;
  logic [HASH_W-1:0]  t_r, t_nxt;
  logic [HASH_W-1:0]  mix;
  logic [SIZE_W-1:0]  rem_r, rem_nxt;
  logic [SIZE_W-1:0]  div_r, div_nxt;
  logic [SIZE_W:0]    trial;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;

  // Effective register values.
  logic [LEN_W-1:0]   eff_len;
  logic [CMP_W-1:0]   fs_ext;
  logic [SIZE_W-1:0]  eff_size;

  // Result holding and output register.
  logic [BUCKET_W-1:0] res_bucket_r, res_bucket_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic                res_pass_r, res_pass_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                out_tuser_r, out_tuser_nxt;
  logic                out_free;

  // Counter RAM.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] cnt_inc;

  logic in_xfer;

  // --------------------------------------------------------------------------
  // Configuration writes. Indexes beyond the register list are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ngram_len_r   <= RST_NGRAM_LEN;
      min_count_r   <= RST_MIN_COUNT;
      num_buckets_r <= RST_NUM_BUCKETS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NGRAM_LEN:   ngram_len_r   <= cfg_wdata[NGRAM_LEN_W-1:0];
        REG_MIN_COUNT:   min_count_r   <= cfg_wdata[MIN_COUNT_W-1:0];
        REG_NUM_BUCKETS: num_buckets_r <= cfg_wdata[NUM_BUCKETS_W-1:0];
        default: ;
      endcase
    end
  end

  // A window length of zero means one token; anything above the window
  // depth is clipped to it. A filter size of zero, or one larger than the
  // RAM, selects the whole RAM.
  always_comb begin
    if (ngram_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if ({1'b0, ngram_len_r} > (NGRAM_LEN_W + 1)'(MAX_NGRAM)) begin
      eff_len = LEN_W'(MAX_NGRAM);
    end else begin
      eff_len = LEN_W'(ngram_len_r);
    end
  end

  assign fs_ext = CMP_W'(num_buckets_r);

  always_comb begin
    if (fs_ext == '0 || fs_ext > CMP_W'(FILTER_ENTRIES)) begin
      eff_size = SIZE_W'(FILTER_ENTRIES);
    end else begin
      eff_size = SIZE_W'(fs_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: fetch the control word for the current step, then hold,
  // jump or fall through to the next step.
  // --------------------------------------------------------------------------
  assign uw       = ucode(pc_r);
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    case (uw.hold)
      H_NONE:     hold = 1'b0;
      H_CLEAR:    hold = (clr_addr_r != ADDR_W'(FILTER_ENTRIES - 1));
      H_NO_INPUT: hold = !in_tvalid;
      H_DIV:      hold = (dcnt_r != DCNT_W'(1));
      H_OUT_BUSY: hold = !out_free;
      default:    hold = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.jump)
      J_NONE:     jump = 1'b0;
      J_ALWAYS:   jump = 1'b1;
      J_NOT_FULL: jump = (fill_r < eff_len);
      J_MORE_TOK: jump = (k_r != LEN_W'(1));
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = uw.tgt;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  assign in_tready = (uw.op == OP_ACCEPT);
  assign in_xfer   = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Datapath. Each operation runs on every cycle its step is active.
  // --------------------------------------------------------------------------
  assign k_m1  = k_r - LEN_W'(1);
  assign mix   = h_r ^ HASH_W'(win_r[k_m1[IDX_W-1:0]]);
  assign trial = {rem_r, h_r[HASH_W-1]};
  assign cnt_inc = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);

  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    req_nxt        = req_r;
    full_nxt       = full_r;
    h_nxt          = h_r;
    x_nxt          = x_r;
    t_nxt          = t_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    dcnt_nxt       = dcnt_r;
    clr_addr_nxt   = clr_addr_r;
    res_bucket_nxt = res_bucket_r;
    res_count_nxt  = res_count_r;
    res_pass_nxt   = res_pass_r;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(rem_r);
    ram_wdata      = cnt_inc;

    case (uw.op)
      OP_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      OP_ACCEPT: begin
        if (in_xfer) begin
          // A document start empties the window before the token enters.
          req_nxt    = in_tuser[0];
          win_nxt[0] = in_tdata[TOKEN_W-1:0];
          for (int i = 1; i < MAX_NGRAM; i++) begin
            win_nxt[i] = in_tuser[1] ? '0 : win_r[i-1];
          end
          if (in_tuser[1]) begin
            fill_nxt = LEN_W'(1);
          end else if (fill_r < LEN_W'(MAX_NGRAM)) begin
            fill_nxt = fill_r + LEN_W'(1);
          end
        end
      end
      OP_HINIT: begin
        h_nxt          = FNV_BASIS;
        k_nxt          = eff_len;
        full_nxt       = (fill_r >= eff_len);
        res_bucket_nxt = '0;
        res_count_nxt  = '0;
        res_pass_nxt   = 1'b0;
      end
      OP_MULA: begin
        x_nxt = mix;
        t_nxt = mix * HASH_W'(FNV_PRIME_LO);
      end
      OP_MULB: begin
        h_nxt = t_r + (x_r << FNV_SHIFT_A) + (x_r << FNV_SHIFT_B);
        k_nxt = k_m1;
      end
      OP_DIVI: begin
        rem_nxt  = '0;
        div_nxt  = eff_size;
        dcnt_nxt = DCNT_W'(DIV_STEPS);
      end
      OP_DIVS: begin
        // Restoring remainder, one hash bit per cycle, most significant first.
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = SIZE_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = SIZE_W'(trial);
        end
        h_nxt    = h_r << 1;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      OP_READ: ;
      OP_UPDATE: begin
        res_bucket_nxt = BUCKET_W'(rem_r);
        if (req_r == REQ_COUNT) begin
          ram_we        = 1'b1;
          res_count_nxt = cnt_inc;
          res_pass_nxt  = 1'b0;
        end else begin
          res_count_nxt = ram_rdata;
          res_pass_nxt  = (ram_rdata >= min_count_r);
        end
      end
      OP_EMIT: ;
      default: ;
    endcase
  end

  // Output register: loaded in the emit step once the slot is free.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (uw.op == OP_EMIT && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {PAD_W'(0), res_pass_r, res_count_r, res_bucket_r};
      out_tuser_nxt  = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_CLEAR;
      fill_r       <= '0;
      k_r          <= '0;
      dcnt_r       <= '0;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      fill_r       <= fill_nxt;
      k_r          <= k_nxt;
      dcnt_r       <= dcnt_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    req_r        <= req_nxt;
    full_r       <= full_nxt;
    h_r          <= h_nxt;
    x_r          <= x_nxt;
    t_r          <= t_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    res_bucket_r <= res_bucket_nxt;
    res_count_r  <= res_count_nxt;
    res_pass_r   <= res_pass_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Counter store. The read address follows the remainder register, so the
  // read step presents the bucket and the update step sees its count.
  ncbf_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (FILTER_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(rem_r)),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_accept_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == S_CHECK))
    else $error("sequencer did not move to the window check after a transfer");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_DIV || pc_r == S_READ) |-> (rem_r < div_r))
    else $error("partial remainder reached the divisor");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(MAX_NGRAM))
    else $error("window fill exceeds window depth");
`endif

endmodule

### test/ngram_bloom_checker.sv
// ----------------------------------------------------------------------------
// ngram_bloom_checker
// Watches the configuration port and both streams of the n-gram counting
// Bloom filter, predicts every result from its own copy of the window, the
// registers and the counter store, and compares each result transfer with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ngram_bloom_checker
  import ncbf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] token_id
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] req_type, [1] doc_start
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] bucket, [23:16] count_value,
                                            // [24] passed, [31:25] zero
  input  logic                  out_tuser,  // [0] ngram_valid
  output int                    fail_count,
  output int                    pending_results
);

  localparam int                WIN_DEPTH = DEF_MAX_NGRAM;
  localparam int                BUCKETS   = DEF_FILTER_ENTRIES;
  localparam logic [HASH_W-1:0] FNV_MULT  = 64'h0000_0100_0000_01B3;

  typedef struct packed {
    logic                ngram_valid;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count_value;
    logic                passed;
  } bloom_result_t;

  logic [NGRAM_LEN_W-1:0]   ngram_len_q;
  logic [MIN_COUNT_W-1:0]   min_count_q;
  logic [NUM_BUCKETS_W-1:0] num_buckets_q;

  // window_q[0] holds the newest token of the current document.
  logic [TOKEN_W-1:0] window_q [WIN_DEPTH];
  int unsigned        window_fill_q;
  logic [COUNT_W-1:0] counter_mem [BUCKETS];
  bloom_result_t      expected_q [$];

  // Advances the window by one token and works out the result it gives,
  // updating the counter store on a count request.
  function automatic bloom_result_t step_filter(input logic req,
                                                input logic [TOKEN_W-1:0] tok,
                                                input logic start);
    bloom_result_t      r;
    int unsigned        n;
    int                 i;
    logic [HASH_W-1:0]  h;
    logic [HASH_W-1:0]  size;
    logic [HASH_W-1:0]  idx;
    logic [COUNT_W-1:0] c;
    r = '0;
    if (ngram_len_q == 0) n = 1;
    else if (ngram_len_q > WIN_DEPTH) n = WIN_DEPTH;
    else n = ngram_len_q;
    if (num_buckets_q == 0 || num_buckets_q > BUCKETS) size = HASH_W'(BUCKETS);
    else size = HASH_W'(num_buckets_q);
    if (start) begin
      for (i = 0; i < WIN_DEPTH; i++) window_q[i] = '0;
      window_fill_q = 0;
    end
    for (i = WIN_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = tok;
    if (window_fill_q < WIN_DEPTH) window_fill_q++;
    if (window_fill_q >= n) begin
      // Hash the window oldest token first.
      h = FNV_BASIS;
      for (i = n; i > 0; i--) h = (h ^ {32'b0, window_q[i-1]}) * FNV_MULT;
      idx = h % size;
      c = counter_mem[idx[BUCKET_W-1:0]];
      if (req == REQ_COUNT) begin
        if (c != CNT_MAX) c = c + 1'b1;
        counter_mem[idx[BUCKET_W-1:0]] = c;
      end else begin
        r.passed = (c >= min_count_q);
      end
      r.ngram_valid = 1'b1;
      r.bucket      = idx[BUCKET_W-1:0];
      r.count_value = c;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned actv, inout int errs);
    if (expv != actv) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    int            errs;
    int            i;
    bloom_result_t exp_r;
    errs = 0;
    if (!rst_n) begin
      ngram_len_q   <= RST_NGRAM_LEN;
      min_count_q   <= RST_MIN_COUNT;
      num_buckets_q <= RST_NUM_BUCKETS;
      for (i = 0; i < WIN_DEPTH; i++) window_q[i] = '0;
      window_fill_q = 0;
      for (i = 0; i < BUCKETS; i++) counter_mem[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_NGRAM_LEN:   ngram_len_q   <= cfg_wdata[NGRAM_LEN_W-1:0];
          REG_MIN_COUNT:   min_count_q   <= cfg_wdata[MIN_COUNT_W-1:0];
          REG_NUM_BUCKETS: num_buckets_q <= cfg_wdata[NUM_BUCKETS_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: expected none, %s 0x%h %b",
                   $time, "actual tdata/tuser", out_tdata, out_tuser);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("ngram_valid", exp_r.ngram_valid, out_tuser, errs);
          check_field("bucket", exp_r.bucket, out_tdata[15:0], errs);
          check_field("count_value", exp_r.count_value, out_tdata[23:16], errs);
          check_field("passed", exp_r.passed, out_tdata[24], errs);
          check_field("tdata padding", 0, out_tdata[31:25], errs);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(),
                          step_filter(in_tuser[0], in_tdata, in_tuser[1]));
    end
    fail_count      <= fail_count + errs;
    pending_results <= expected_q.size();
  end

endmodule

### test/tb_ngram_counting_bloom_filter.sv
// ----------------------------------------------------------------------------
// tb_ngram_counting_bloom_filter
// Stimulus and verdict for the n-gram counting Bloom filter. A short
// directed run covers the field extremes, both request kinds, document
// starts and the out-of-range register values; a long random run follows,
// made mostly of documents over a small vocabulary so that n-grams repeat
// and counters climb, with stray document marks as noise. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ngram_counting_bloom_filter;
  import ncbf_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  // The block sweeps its 64K-entry counter store after reset before it takes
  // any input, so the watchdog has to sit comfortably above that.
  localparam int WATCHDOG_LIMIT = 200000;
  // Time allowed after the final drain before the verdict is given.
  localparam int DRAIN_CYCLES = 120;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [31:0] token_id
  logic [IN_USER_W-1:0]  in_tuser   = '0;   // [0] req_type, [1] doc_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] bucket, [23:16] count_value,
                                            // [24] passed, [31:25] zero
  logic                  out_tuser;         // [0] ngram_valid

  int fail_count;
  int pending_results;

  // When set, neither side idles: every cycle can carry a transfer.
  bit burst_mode  = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;
  // Tokens still to come in the current random document.
  int doc_left    = 0;

  always #6 clk = ~clk;

  ngram_counting_bloom_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ngram_bloom_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side back-pressure with random stalls; now and then the receiver
  // holds off for a long stretch so that a result waits in the block's output
  // register while the block carries on with the next item.
  always @(posedge clk) begin : receiver
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (r < 15) begin
      out_tready <= 1'b0;
      stall_left <= (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // The watchdog counts cycles in which no transfer and no register write
  // happens, and gives up once the block has clearly stopped.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle cycles before the next input transfer: mostly short gaps, with the
  // odd long gap, and none in burst mode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one token and returns at the edge where the transfer happens.
  // With no gap, tvalid simply stays high and the next token follows
  // directly.
  task automatic send_token(input logic req, input logic [TOKEN_W-1:0] tok,
                            input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tok;
    in_tuser  <= {start, req};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Registers are only ever written with no result outstanding, so the drain
  // comes first. All three are written, on consecutive cycles.
  task automatic program_filter(input logic [CFG_DATA_W-1:0] len_w,
                                input logic [CFG_DATA_W-1:0] minc_w,
                                input logic [CFG_DATA_W-1:0] size_w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_NGRAM_LEN;
    cfg_wdata <= len_w;
    @(posedge clk);
    cfg_addr  <= REG_MIN_COUNT;
    cfg_wdata <= minc_w;
    @(posedge clk);
    cfg_addr  <= REG_NUM_BUCKETS;
    cfg_wdata <= size_w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random documents of 1 to 16 tokens. Most tokens come from a vocabulary of
  // eight ids so that the same n-grams recur; the rest are the extremes or
  // fully random. One token in twenty has its document mark flipped, which
  // gives both stray document starts and documents that run into each other.
  task automatic send_stream(input int n_items, input int count_pct);
    int                 k;
    int                 r;
    logic               req;
    logic               start;
    logic [TOKEN_W-1:0] tok;
    for (k = 0; k < n_items; k++) begin
      // Now and then the sender waits for the block to empty completely.
      if (!burst_mode && $urandom_range(0, 59) == 0) drain_results();
      start = 1'b0;
      if (doc_left == 0) begin
        start    = 1'b1;
        doc_left = $urandom_range(1, 16);
      end
      doc_left--;
      if ($urandom_range(0, 19) == 0) start = ~start;
      r = $urandom_range(0, 99);
      if (r < 70) tok = $urandom_range(0, 7);
      else if (r < 78) tok = r[0] ? '1 : '0;
      else tok = $urandom;
      req = ($urandom_range(0, 99) < count_pct) ? REQ_COUNT : REQ_QUERY;
      send_token(req, tok, start);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] len_w;
    logic [CFG_DATA_W-1:0] minc_w;
    logic [CFG_DATA_W-1:0] size_w;
    int                    phase_items;
    int                    total;
    int                    r;
    int                    k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, default-like settings. The first token of a document
    // leaves a bigram window short, so it must give an empty result; the
    // same bigram counted twice then passes a query at threshold two.
    program_filter(2, 2, 17'h1_0000);
    send_token(REQ_COUNT, 32'h0000_0000, 1'b1);
    send_token(REQ_COUNT, 32'hFFFF_FFFF, 1'b0);
    send_token(REQ_COUNT, 32'h0000_0000, 1'b1);
    send_token(REQ_COUNT, 32'hFFFF_FFFF, 1'b0);
    send_token(REQ_QUERY, 32'h0000_0000, 1'b1);
    send_token(REQ_QUERY, 32'hFFFF_FFFF, 1'b0);
    send_token(REQ_QUERY, 32'hFFFF_FFFF, 1'b0);
    // Two document starts in a row: the window is emptied each time.
    send_token(REQ_COUNT, 32'hA5A5_5A5A, 1'b1);
    send_token(REQ_QUERY, 32'h0000_0001, 1'b1);

    // A zero length behaves as one, a zero size as the full store, and a
    // zero threshold lets every valid query pass, even on an empty bucket.
    program_filter(0, 0, 0);
    send_token(REQ_QUERY, 32'h1234_5678, 1'b1);
    send_token(REQ_COUNT, 32'h1234_5678, 1'b0);
    send_token(REQ_QUERY, 32'h1234_5678, 1'b1);

    // A length above the window depth saturates at ten tokens; a size above
    // the store uses the full store; the highest threshold.
    program_filter(17'h0_000F, 255, 17'h1_FFFF);
    for (k = 0; k < 11; k++)
      send_token(REQ_COUNT, 32'h0101_0101 * k, k == 0);
    send_token(REQ_QUERY, 32'h0000_000B, 1'b0);

    // Everything lands in one bucket, so the counter climbs toward saturation.
    program_filter(1, 255, 1);
    send_stream(280, 85);
    total = 280;

    // Random phases, each with fresh settings, extremes among them.
    while (total < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) len_w = 0;
      else if (r == 1) len_w = 15;
      else if (r == 2) len_w = 10;
      else if (r == 3) len_w = 1;
      else len_w = CFG_DATA_W'($urandom_range(2, 9));
      // Bits above a register's width must be ignored.
      if ($urandom_range(0, 3) == 0)
        len_w[CFG_DATA_W-1:NGRAM_LEN_W] = (CFG_DATA_W - NGRAM_LEN_W)'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) minc_w = 0;
      else if (r < 3) minc_w = 1;
      else if (r < 5) minc_w = CFG_DATA_W'($urandom_range(2, 3));
      else if (r == 5) minc_w = 255;
      else minc_w = CFG_DATA_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0)
        minc_w[CFG_DATA_W-1:MIN_COUNT_W] = (CFG_DATA_W - MIN_COUNT_W)'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) size_w = 0;
      else if (r == 1) size_w = CFG_DATA_W'($urandom_range(1, 3));
      else if (r < 5) size_w = CFG_DATA_W'($urandom_range(1, 64));
      else if (r < 7) size_w = CFG_DATA_W'($urandom_range(1, 65536));
      else if (r == 7) size_w = 17'h1_0000;
      else if (r == 8) size_w = CFG_DATA_W'($urandom_range(65537, 131071));
      else size_w = CFG_DATA_W'($urandom_range(65000, 65536));
      program_filter(len_w, minc_w, size_w);
      burst_mode <= ($urandom_range(0, 4) == 0);
      phase_items = $urandom_range(40, 90);
      send_stream(phase_items, 60);
      total += phase_items;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
